FILE: hw/rtl/bpi_pkg.sv
// shared widths, constants and control types of the band power integrator
package bpi_pkg;

  localparam int CH_W       = 3;
  localparam int BIN_W      = 12;
  localparam int SMP_W      = 32;
  localparam int TS_W       = 63;
  localparam int ACC_W      = 48;
  localparam int TOD_W      = 37;
  localparam int ITIME_W    = 40;
  localparam int INV_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 40;

  // bins at or beyond this count are dropped
  localparam int SPECTRUM_BINS = 4096;

  // microseconds in one day
  localparam logic [TOD_W-1:0] DAY_US  = 37'd86400000000;
  localparam logic [ACC_W-1:0] ACC_MAX = '1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_STOP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INT_TIME   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_BW     = 2'd3;

  // configuration reset values
  localparam logic [BIN_W-1:0]   START_RST = 12'd0;
  localparam logic [BIN_W-1:0]   STOP_RST  = 12'd4095;
  localparam logic [ITIME_W-1:0] ITIME_RST = 40'd1000000;
  localparam logic [INV_W-1:0]   INV_RST   = 32'd65536;

  // accumulator memory control
  typedef struct packed {
    logic upd_en;
    logic rd_en;
    logic clr;
  } bpi_acc_ctl_t;

endpackage

FILE: hw/rtl/bpi_if.sv
// valid/ready channels for spectrum samples and band power results
interface bpi_in_if;
  import bpi_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CH_W-1:0]         channel;
  logic [BIN_W-1:0]        bin;
  logic signed [SMP_W-1:0] sample;
  logic                    frame_end;
  logic [TS_W-1:0]         timestamp_us;

  modport source (output valid, channel, bin, sample, frame_end, timestamp_us, input ready);
  modport sink (input valid, channel, bin, sample, frame_end, timestamp_us, output ready);
endinterface

interface bpi_out_if;
  import bpi_pkg::*;

  logic             valid;
  logic             ready;
  logic [CH_W-1:0]  out_channel;
  logic [ACC_W-1:0] band_power;
  logic [TOD_W-1:0] time_of_day_us;
  logic             last;

  modport source (output valid, out_channel, band_power, time_of_day_us, last, input ready);
  modport sink (input valid, out_channel, band_power, time_of_day_us, last, output ready);
endinterface

FILE: hw/rtl/bpi_acc.sv
// per-channel accumulator memory with read-modify-write and write forwarding
module bpi_acc #(
  parameter int NUM_CHANNELS = 8,
  parameter int CH_AW        = 3
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  bpi_pkg::bpi_acc_ctl_t      ctl,
  input  logic [CH_AW-1:0]           upd_addr,
  input  logic [bpi_pkg::SMP_W-1:0]  upd_mag,
  input  logic [CH_AW-1:0]           rd_addr,
  output logic [bpi_pkg::ACC_W-1:0]  rd_data
);
  import bpi_pkg::*;

  logic [ACC_W-1:0]        mem [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] vld_r;

  logic [CH_AW-1:0] raddr;
  logic [ACC_W-1:0] rdata_r;
  logic             rvld_r;

  logic             s1_en_r;
  logic [CH_AW-1:0] s1_addr_r;
  logic [SMP_W-1:0] s1_mag_r;

  logic             fw_en_r;
  logic [CH_AW-1:0] fw_addr_r;
  logic [ACC_W-1:0] fw_data_r;

  logic [ACC_W-1:0] old_acc;
  logic [ACC_W:0]   sum_w;
  logic [ACC_W-1:0] new_acc;

  assign raddr = ctl.rd_en ? rd_addr : upd_addr;

  // synchronous read port
  always_ff @(posedge clk) begin
    if (ctl.rd_en || ctl.upd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rvld_r <= 1'b0;
    end else if (ctl.rd_en || ctl.upd_en) begin
      rvld_r <= vld_r[raddr];
    end
  end

  // write from the previous cycle collides with this read
  assign old_acc = (fw_en_r && (fw_addr_r == s1_addr_r)) ? fw_data_r :
                   (rvld_r ? rdata_r : '0);
  assign sum_w   = {1'b0, old_acc} + {{(ACC_W + 1 - SMP_W){1'b0}}, s1_mag_r};
  assign new_acc = sum_w[ACC_W] ? ACC_MAX : sum_w[ACC_W-1:0];

  always_ff @(posedge clk) begin
    if (s1_en_r) begin
      mem[s1_addr_r] <= new_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_en_r <= 1'b0;
      fw_en_r <= 1'b0;
      vld_r   <= '0;
    end else begin
      s1_en_r <= ctl.upd_en;
      fw_en_r <= s1_en_r;
      if (ctl.clr) begin
        vld_r <= '0;
      end else if (s1_en_r) begin
        vld_r[s1_addr_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_addr_r <= upd_addr;
    s1_mag_r  <= upd_mag;
    fw_addr_r <= s1_addr_r;
    fw_data_r <= new_acc;
  end

  assign rd_data = rvld_r ? rdata_r : '0;

endmodule

FILE: hw/rtl/bpi_tod.sv
// time of day remainder by reciprocal multiplication, pipelined
module bpi_tod (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [bpi_pkg::TS_W-1:0]  ts,
  output logic                      done,
  output logic [bpi_pkg::TOD_W-1:0] tod
);
  import bpi_pkg::*;

  // one day is 2^13 times an odd factor; the low 13 bits pass straight through
  localparam int SH_W   = 13;
  localparam int X_W    = TS_W - SH_W;
  localparam int ODD_W  = TOD_W - SH_W;
  localparam int M_W    = 25;
  localparam int RCP_SH = 48;
  localparam int LO_W   = 32;
  localparam int HI_W   = X_W - LO_W;
  localparam int PA_W   = LO_W + M_W;
  localparam int PB_W   = HI_W + M_W;
  localparam int SUM_W  = X_W + M_W;
  localparam int Q_W    = SUM_W - RCP_SH;
  localparam int QD_W   = Q_W + ODD_W;
  // remainder before correction stays below five times the odd factor
  localparam int R_W    = 27;

  localparam logic [ODD_W-1:0] D_ODD = ODD_W'(DAY_US >> SH_W);
  // quotient estimate falls at most four short of the true quotient
  localparam logic [M_W-1:0]   RECIP = M_W'((64'd1 << RCP_SH) / 64'(D_ODD));
  localparam logic [R_W-1:0]   D1    = R_W'(D_ODD);
  localparam logic [R_W-1:0]   D2    = D1 + D1;
  localparam logic [R_W-1:0]   D3    = D2 + D1;
  localparam logic [R_W-1:0]   D4    = D2 + D2;

  logic [3:0]       v_r;
  logic             done_r;
  logic [X_W-1:0]   x_r;
  logic [SH_W-1:0]  lo_r;
  logic [PA_W-1:0]  pa_r;
  logic [PB_W-1:0]  pb_r;
  logic [SUM_W-1:0] qsum;
  logic [Q_W-1:0]   q_r;
  logic [QD_W-1:0]  qd;
  logic [R_W-1:0]   r_r;
  logic [R_W-1:0]   fix;
  logic [ODD_W-1:0] rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r    <= '0;
      done_r <= 1'b0;
    end else begin
      v_r    <= {v_r[2:0], start};
      done_r <= v_r[3];
    end
  end

  assign qsum = SUM_W'(pa_r) + {pb_r, {LO_W{1'b0}}};
  assign qd   = QD_W'(q_r) * QD_W'(D_ODD);

  // final correction by up to four times the odd factor
  always_comb begin
    priority if (r_r >= D4) begin
      fix = r_r - D4;
    end else if (r_r >= D3) begin
      fix = r_r - D3;
    end else if (r_r >= D2) begin
      fix = r_r - D2;
    end else if (r_r >= D1) begin
      fix = r_r - D1;
    end else begin
      fix = r_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r  <= ts[TS_W-1:SH_W];
      lo_r <= ts[SH_W-1:0];
    end
    pa_r <= PA_W'(x_r[LO_W-1:0]) * PA_W'(RECIP);
    pb_r <= PB_W'(x_r[X_W-1:LO_W]) * PB_W'(RECIP);
    q_r  <= qsum[SUM_W-1:RCP_SH];
    r_r  <= x_r[R_W-1:0] - qd[R_W-1:0];
    if (v_r[3]) begin
      rem_r <= fix[ODD_W-1:0];
    end
  end

  assign done = done_r;
  assign tod  = {rem_r, lo_r};

endmodule

FILE: hw/rtl/bpi_scale.sv
// accumulator times reciprocal bandwidth, two partial products, saturated
module bpi_scale (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_vld,
  input  logic [bpi_pkg::ACC_W-1:0] acc,
  input  logic [bpi_pkg::INV_W-1:0] inv,
  output logic                      out_vld,
  output logic [bpi_pkg::ACC_W-1:0] power
);
  import bpi_pkg::*;

  localparam int LO_W   = 32;
  localparam int HI_W   = ACC_W - LO_W;
  localparam int PL_W   = LO_W + INV_W;
  localparam int PH_W   = HI_W + INV_W;
  localparam int PROD_W = ACC_W + INV_W;
  localparam int FRAC_W = 16;
  localparam int KEEP_W = 64;

  logic              va_r;
  logic              vb_r;
  logic [PL_W-1:0]   pl_r;
  logic [PH_W-1:0]   ph_r;
  logic [PROD_W-1:0] prod;
  logic [ACC_W-1:0]  power_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      va_r <= in_vld;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    pl_r <= PL_W'(acc[LO_W-1:0]) * PL_W'(inv);
    ph_r <= PH_W'(acc[ACC_W-1:LO_W]) * PH_W'(inv);
  end

  assign prod = PROD_W'(pl_r) + {ph_r, {LO_W{1'b0}}};

  // products past 64 bits saturate
  always_ff @(posedge clk) begin
    power_r <= (|prod[PROD_W-1:KEEP_W]) ? ACC_MAX : prod[KEEP_W-1:FRAC_W];
  end

  assign out_vld = vb_r;
  assign power   = power_r;

endmodule

FILE: hw/rtl/band_power_integrator.sv
// band power integrator top level: sample intake, integration timing, emission
//
// Sums |sample| per channel over bins band_start_bin..band_stop_bin (inclusive)
// and, on a frame end whose timestamp is at least integration_time_us past the
// integration start (latched on the first frame end of an integration), emits
// one item per channel, channel 0 first, with band_power = sum * inverse_bandwidth
// >> 16 saturated to 48 bits and the timestamp modulo one day; last marks the
// final channel. Accumulators sit in a NUM_CHANNELS x 48 memory: read when a
// sample is accepted, updated and written back the next cycle, with the write
// forwarded to a read of the same channel issued at that edge; valid bits
// clear the memory at reset and after each emission. Samples go in at one
// per cycle while the input is open. A frame-end item holds in_ready low
// while the elapsed time is checked. An emitting frame end keeps the input
// closed through the check, the pipelined time-of-day remainder unit, then per
// channel a memory read, an operand step and two multiplier stages before the
// output register, plus any output stall. Input reopens as soon as the last
// result is loaded into the output register.
module band_power_integrator #(
  parameter int NUM_CHANNELS = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  bpi_in_if.sink                         in_if,
  bpi_out_if.source                      out_if,
  input  logic                           cfg_we,
  input  logic [bpi_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [bpi_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import bpi_pkg::*;

  localparam int CH_AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // sequencer states
  localparam logic [2:0] ST_RUN = 3'd0;  // taking samples
  localparam logic [2:0] ST_TOD = 3'd1;  // time of day remainder
  localparam logic [2:0] ST_RD  = 3'd2;  // read one accumulator
  localparam logic [2:0] ST_LD  = 3'd3;  // feed multiplier
  localparam logic [2:0] ST_MUL = 3'd4;  // wait for scaled power

  // configuration
  logic [BIN_W-1:0]   start_bin_r;
  logic [BIN_W-1:0]   stop_bin_r;
  logic [ITIME_W-1:0] itime_r;
  logic [INV_W-1:0]   inv_bw_r;

  // integration state
  logic            new_int_r;
  logic [TS_W-1:0] start_r;
  logic            fe_vld_r;
  logic [TS_W-1:0] fe_ts_r;
  logic [TS_W-1:0] start_eff;
  logic [TS_W-1:0] elapsed;
  logic            emit;

  logic [2:0]       state_r;
  logic [CH_AW-1:0] k_r;
  logic             k_last;

  // intake
  logic             in_hs;
  logic             in_ok;
  logic [SMP_W-1:0] smp_u;
  logic [SMP_W-1:0] mag;

  // accumulator memory, tod unit, scaler
  bpi_acc_ctl_t     acc_ctl;
  logic [ACC_W-1:0] acc_rd;
  logic             tod_start;
  logic             tod_done;
  logic [TOD_W-1:0] tod;
  logic             sc_vld;
  logic [ACC_W-1:0] sc_power;

  // output register
  logic             out_hs;
  logic             slot_free;
  logic             load;
  logic             out_vld_r;
  logic [CH_W-1:0]  out_ch_r;
  logic [ACC_W-1:0] out_pwr_r;
  logic [TOD_W-1:0] out_tod_r;
  logic             out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_bin_r <= START_RST;
      stop_bin_r  <= STOP_RST;
      itime_r     <= ITIME_RST;
      inv_bw_r    <= INV_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_BAND_START: start_bin_r <= cfg_wdata[BIN_W-1:0];
        CFG_BAND_STOP:  stop_bin_r  <= cfg_wdata[BIN_W-1:0];
        CFG_INT_TIME:   itime_r     <= cfg_wdata[ITIME_W-1:0];
        CFG_INV_BW:     inv_bw_r    <= cfg_wdata[INV_W-1:0];
      endcase
    end
  end

  // intake: a frame end closes the input for the timing check
  assign in_if.ready = (state_r == ST_RUN) && !fe_vld_r;
  assign in_hs       = in_if.valid && in_if.ready;

  assign in_ok = (32'(in_if.channel) < NUM_CHANNELS) &&
                 (32'(in_if.bin) < SPECTRUM_BINS) &&
                 (in_if.bin >= start_bin_r) && (in_if.bin <= stop_bin_r);

  // most negative sample gives 2^31
  assign smp_u = in_if.sample;
  assign mag   = smp_u[SMP_W-1] ? (~smp_u + SMP_W'(1)) : smp_u;

  // elapsed time check on the frame end item
  assign start_eff = new_int_r ? fe_ts_r : start_r;
  assign elapsed   = fe_ts_r - start_eff;
  assign emit      = (fe_ts_r >= start_eff) && (elapsed >= TS_W'(itime_r));

  assign tod_start = (state_r == ST_RUN) && fe_vld_r && emit;

  assign k_last    = (k_r == CH_AW'(NUM_CHANNELS - 1));
  assign out_hs    = out_if.valid && out_if.ready;
  assign slot_free = !out_vld_r || out_hs;
  assign load      = (state_r == ST_MUL) && sc_vld;

  assign acc_ctl.upd_en = in_hs && in_ok;
  assign acc_ctl.rd_en  = (state_r == ST_RD) && slot_free;
  assign acc_ctl.clr    = load && k_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_RUN;
      fe_vld_r  <= 1'b0;
      new_int_r <= 1'b1;
      start_r   <= '0;
      k_r       <= '0;
    end else begin
      fe_vld_r <= in_hs && in_if.frame_end;
      unique case (state_r)
        ST_RUN: begin
          if (fe_vld_r) begin
            if (new_int_r) begin
              start_r   <= fe_ts_r;
              new_int_r <= 1'b0;
            end
            if (emit) begin
              new_int_r <= 1'b1;
              state_r   <= ST_TOD;
            end
          end
        end
        ST_TOD: begin
          if (tod_done) begin
            k_r     <= '0;
            state_r <= ST_RD;
          end
        end
        ST_RD: begin
          if (slot_free) begin
            state_r <= ST_LD;
          end
        end
        ST_LD: begin
          state_r <= ST_MUL;
        end
        ST_MUL: begin
          if (sc_vld) begin
            if (k_last) begin
              state_r <= ST_RUN;
            end else begin
              k_r     <= k_r + CH_AW'(1);
              state_r <= ST_RD;
            end
          end
        end
        default: state_r <= ST_RUN;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_hs) begin
      fe_ts_r <= in_if.timestamp_us;
    end
  end

  bpi_acc #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .CH_AW        (CH_AW)
  ) u_acc (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (acc_ctl),
    .upd_addr (CH_AW'(in_if.channel)),
    .upd_mag  (mag),
    .rd_addr  (k_r),
    .rd_data  (acc_rd)
  );

  bpi_tod u_tod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (tod_start),
    .ts    (fe_ts_r),
    .done  (tod_done),
    .tod   (tod)
  );

  bpi_scale u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (state_r == ST_LD),
    .acc     (acc_rd),
    .inv     (inv_bw_r),
    .out_vld (sc_vld),
    .power   (sc_power)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (load) begin
      out_vld_r <= 1'b1;
    end else if (out_hs) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_ch_r   <= CH_W'(k_r);
      out_pwr_r  <= sc_power;
      out_tod_r  <= tod;
      out_last_r <= k_last;
    end
  end

  assign out_if.valid          = out_vld_r;
  assign out_if.out_channel    = out_ch_r;
  assign out_if.band_power     = out_pwr_r;
  assign out_if.time_of_day_us = out_tod_r;
  assign out_if.last           = out_last_r;

`ifndef ASSERT_OFF
  // samples only enter while the sequencer is idle
  a_accept_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    in_hs |-> (state_r == ST_RUN))
    else $error("item accepted during emission");

  // a scaled result never overwrites a pending one
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> !out_vld_r)
    else $error("output register overwritten");

  // memory port is never claimed by intake and emission together
  a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(acc_ctl.upd_en && acc_ctl.rd_en))
    else $error("accumulator port conflict");

  // remainder finishes only while waited for
  a_tod_done: assert property (@(posedge clk) disable iff (!rst_n)
    tod_done |-> (state_r == ST_TOD))
    else $error("time of day done outside wait");
`endif

endmodule
